/* design/fpa_pkg.sv */
// Shared constants and types for the 16-bit float adder.
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned ExpW  = 7;
  // aligned mantissa: carry bit 12, hidden 11, fraction 10..3, guard/round/sticky 2..0
  localparam int unsigned MantW = 13;
  localparam logic [ExpW-1:0]  ExpMaxField = 7'h7f;
  localparam logic [WordW-1:0] NanOppInf   = 16'hff01;
  localparam logic [WordW-1:0] PosInf      = 16'h7f00;
  localparam logic [WordW-1:0] NegInf      = 16'hff00;

  // Stage 1 -> 2: ordered operands after alignment.
  typedef struct packed {
    logic             special;    // result already decided
    logic [WordW-1:0] special_val;
    logic             sign;
    logic             subtract;
    logic [7:0]       exp_b;      // biased exponent, 1 for subnormals
    logic [MantW-1:0] mx;
    logic [MantW-1:0] my;
  } align_t;

  // Stage 2 -> 3: raw sum with normalization shift chosen.
  typedef struct packed {
    logic             special;
    logic [WordW-1:0] special_val;
    logic             sign;
    logic [7:0]       exp_b;
    logic [MantW-1:0] r;
    logic [3:0]       lshift;
  } sum_t;

  // Stage 3 -> out: normalized, not yet rounded.
  typedef struct packed {
    logic             special;
    logic [WordW-1:0] special_val;
    logic             sign;
    logic [7:0]       exp_b;
    logic [11:0]      r;
  } norm_t;

endpackage

/* design/fp16_adder_rne.sv */
// Top level of the pipelined 16-bit float adder, round to nearest even.
//
//  channel | signals                                     | direction
//  in      | in_valid_i, in_stall_o, operand_a_i/b_i     | into block
//  out     | out_valid_o, out_stall_i, sum_value_o       | out of block
//
// The pipe has one register stage each for align, add, normalize and round.
// One operand pair is taken every cycle when the output is not stalled.
// A stall on the output freezes the whole pipe; a stage moves only if the last is free.
// Reset clears only the valid bits; data registers are not reset.
`timescale 1ns / 1ps
module fp16_adder_rne (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] sum_value_o
);

  logic adv;

  // Pipe advances unless a finished beat is held at the output
  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  fpa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .a_i         (operand_a_i),
    .b_i         (operand_b_i),
    .out_valid_o (out_valid_o),
    .sum_o       (sum_value_o)
  );

endmodule

/* design/fpa_core.sv */
// Four-stage datapath: align, add, normalize, round.
`timescale 1ns / 1ps
module fpa_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         in_valid_i,
  input  logic [fpa_pkg::WordW-1:0]    a_i,
  input  logic [fpa_pkg::WordW-1:0]    b_i,
  output logic                         out_valid_o,
  output logic [fpa_pkg::WordW-1:0]    sum_o
);

  logic [3:0] vld_q;
  fpa_pkg::align_t s1_d, s1_q;
  fpa_pkg::sum_t   s2_d, s2_q;
  fpa_pkg::norm_t  s3_d, s3_q;
  logic [fpa_pkg::WordW-1:0] res_d, res_q;

  // Stage 1: order, classify, align the smaller operand
  logic [15:0] x, y;
  logic [6:0]  ex, ey;
  logic [7:0]  e1x, e1y, dd;
  logic        xnan, ynan, xinf, yinf, xz, yz;
  logic [12:0] my0, lostm;
  always_comb begin
    if ((a_i | 16'h8000) < (b_i | 16'h8000)) begin
      x = b_i; y = a_i;
    end else begin
      x = a_i; y = b_i;
    end
    ex = x[14:8]; ey = y[14:8];
    xnan = (ex == fpa_pkg::ExpMaxField) && (x[7:0] != 8'd0);
    ynan = (ey == fpa_pkg::ExpMaxField) && (y[7:0] != 8'd0);
    xinf = (ex == fpa_pkg::ExpMaxField) && (x[7:0] == 8'd0);
    yinf = (ey == fpa_pkg::ExpMaxField) && (y[7:0] == 8'd0);
    xz = (x[14:0] == 15'd0);
    yz = (y[14:0] == 15'd0);
    e1x = (ex == 7'd0) ? 8'd1 : {1'b0, ex};
    e1y = (ey == 7'd0) ? 8'd1 : {1'b0, ey};
    dd = e1x - e1y;
    s1_d.special = 1'b1;
    priority if (xnan) s1_d.special_val = x;
    else if (ynan) s1_d.special_val = y;
    else if (xinf) s1_d.special_val = (yinf && (x[15] ^ y[15])) ? fpa_pkg::NanOppInf : x;
    else if (yinf) s1_d.special_val = y;
    else if (xz) s1_d.special_val = y;
    else if (yz) s1_d.special_val = x;
    else begin
      s1_d.special = 1'b0;
      s1_d.special_val = x;
    end
    s1_d.sign = x[15];
    s1_d.subtract = x[15] ^ y[15];
    s1_d.exp_b = e1x;
    s1_d.mx = {1'b0, (ex != 7'd0), x[7:0], 3'b000};
    my0 = {1'b0, (ey != 7'd0), y[7:0], 3'b000};
    lostm = 13'd0;
    if (dd >= 8'd12) begin
      s1_d.my = {12'd0, (my0 != 13'd0)};
    end else begin
      lostm = my0 & ~(13'h1fff << dd[3:0]);
      s1_d.my = (my0 >> dd[3:0]) | {12'd0, (lostm != 13'd0)};
    end
  end

  // Stage 2: add or subtract, find leading one
  logic [12:0] rr;
  logic [3:0]  lz;
  always_comb begin
    rr = s1_q.subtract ? (s1_q.mx - s1_q.my) : (s1_q.mx + s1_q.my);
    lz = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (rr[i]) lz = 4'(11 - i);
    end
    s2_d.special = s1_q.special || (rr == 13'd0);
    s2_d.special_val = s1_q.special ? s1_q.special_val : 16'h0000;
    s2_d.sign = s1_q.sign;
    s2_d.exp_b = s1_q.exp_b;
    s2_d.r = rr;
    s2_d.lshift = lz;
  end

  // Stage 3: normalize, limited by the minimum exponent
  logic [3:0]  sh;
  logic [12:0] rs;
  always_comb begin
    s3_d.special = s2_q.special;
    s3_d.special_val = s2_q.special_val;
    s3_d.sign = s2_q.sign;
    sh = 4'd0;
    rs = s2_q.r;
    if (s2_q.r[12]) begin
      s3_d.r = s2_q.r[12:1] | {11'd0, s2_q.r[0]};
      s3_d.exp_b = s2_q.exp_b + 8'd1;
    end else begin
      sh = ({4'd0, s2_q.lshift} <= s2_q.exp_b - 8'd1) ? s2_q.lshift : 4'((s2_q.exp_b - 8'd1));
      rs = s2_q.r << sh;
      s3_d.r = rs[11:0];
      s3_d.exp_b = s2_q.exp_b - {4'd0, sh};
    end
  end

  // Stage 4: round to nearest even, pack
  logic [11:0] r2;
  logic [9:0]  q;
  logic [7:0]  eo;
  logic [6:0]  fld;
  always_comb begin
    r2 = {1'b0, s3_q.r[11:1]} | {11'd0, s3_q.r[0]};
    q = r2[11:2];
    eo = s3_q.exp_b;
    if (r2[1] && (r2[0] || q[0])) q = q + 10'd1;
    if (q[9]) begin
      q = q >> 1;
      eo = eo + 8'd1;
    end
    fld = (eo == 8'd1) ? {6'd0, q[8]} : eo[6:0];
    if (s3_q.special) res_d = s3_q.special_val;
    else if (eo > 8'd126) res_d = s3_q.sign ? fpa_pkg::NegInf : fpa_pkg::PosInf;
    else res_d = {s3_q.sign, fld, q[7:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q[3];
  assign sum_o = res_q;

  // A stalled pipe holds its valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni) !adv_i |=> $stable(vld_q))
    else $error("valid bits moved during stall");
  // A valid beat leaving the normalize stage reaches the output on an advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && vld_q[2] |=> vld_q[3])
    else $error("beat lost between stages");
  // Held result stays put while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni) !adv_i |=> $stable(res_q))
    else $error("result changed during stall");

endmodule

/* bench/fp16_sum_checker.sv */
// Checker for the 16-bit float adder: predicts each sum and compares it.
`timescale 1ns / 1ps
module fp16_sum_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] sum_value_i,
  output int          errors_o,
  output int          pending_o
);

  logic [15:0] sums_due[$];
  int          err_cnt = 0;
  int          due_cnt = 0;

  function automatic logic is_nan16(logic [15:0] v);
    return v[14:8] == fpa_pkg::ExpMaxField && v[7:0] != 8'h00;
  endfunction

  function automatic logic is_inf16(logic [15:0] v);
    return v[14:8] == fpa_pkg::ExpMaxField && v[7:0] == 8'h00;
  endfunction

  // Rounded sum of two floats in the 1/7/8 format.
  function automatic logic [15:0] fp16_sum(logic [15:0] a, logic [15:0] b);
    logic [15:0] x, y;
    logic        sgn, sub, gbit, sbit;
    int          e, ey, d;
    logic [31:0] mx, my, r, q, fld;
    x = a;
    y = b;
    if ((a | 16'h8000) < (b | 16'h8000)) begin
      x = b;
      y = a;
    end
    if (is_nan16(x)) return x;
    if (is_nan16(y)) return y;
    if (is_inf16(x)) begin
      if (is_inf16(y) && (x[15] != y[15])) return fpa_pkg::NanOppInf;
      return x;
    end
    if (is_inf16(y)) return y;
    if (x[14:0] == 15'd0) return y;
    if (y[14:0] == 15'd0) return x;
    sgn = x[15];
    sub = x[15] ^ y[15];
    e  = (x[14:8] == 0) ? -62 : int'(x[14:8]) - 63;
    ey = (y[14:8] == 0) ? -62 : int'(y[14:8]) - 63;
    mx = {23'd0, x[14:8] != 0, x[7:0]} << 3;
    my = {23'd0, y[14:8] != 0, y[7:0]} << 3;
    d = e - ey;
    // align smaller operand, keeping a sticky bit
    if (d >= 12) my = (my != 0) ? 32'd1 : 32'd0;
    else if (d > 0) my = (my >> d) | {31'd0, (my & ((32'd1 << d) - 32'd1)) != 32'd0};
    r = sub ? mx - my : mx + my;
    if (r == 0) return 16'h0000;
    if (r[12]) begin
      r = (r >> 1) | (r & 32'd1);
      e++;
    end else begin
      while (!r[11] && e > -62) begin
        r = r << 1;
        e--;
      end
    end
    // fold round into sticky, then nearest even
    r = (r >> 1) | (r & 32'd1);
    gbit = r[1];
    sbit = r[0];
    q = r >> 2;
    if (gbit && (sbit || q[0])) q++;
    if (q[9]) begin
      q = q >> 1;
      e++;
    end
    if (e > 63) return sgn ? fpa_pkg::NegInf : fpa_pkg::PosInf;
    fld = (e == -62) ? {31'd0, q[8]} : 32'(e + 63);
    return {sgn, fld[6:0], q[7:0]};
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  assign errors_o = err_cnt;
  assign pending_o = due_cnt;

  // Sample beats on the rising edge.
  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) sums_due.push_back(fp16_sum(operand_a_i, operand_b_i));
      if (out_valid_i && !out_stall_i) begin
        if (sums_due.size() == 0) begin
          report_mismatch($sformatf("unexpected sum %h", sum_value_i));
        end else begin
          want = sums_due.pop_front();
          if (sum_value_i !== want)
            report_mismatch($sformatf("sum %h, want %h", sum_value_i, want));
        end
      end
      due_cnt = sums_due.size();
    end
  end
endmodule

/* bench/tb_top.sv */
// Testbench top for the 16-bit float adder: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb_top;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] operand_a_i = '0;
  logic [15:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] sum_value_o;
  int          errors, pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_off = 1'b0;
  logic [15:0] directed_a[$], directed_b[$];

  fp16_adder_rne uut (.*);

  fp16_sum_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .operand_a_i, .operand_b_i,
    .out_valid_i(out_valid_o), .out_stall_i, .sum_value_i(sum_value_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Random operand, biased toward nearby exponents and special values.
  function automatic logic [15:0] pick_operand(logic [15:0] other);
    logic [15:0] v;
    int          k;
    k = $urandom_range(9);
    v = 16'($urandom());
    if (k == 0) v[14:8] = 7'h7f;
    else if (k == 1) v[14:8] = 7'h00;
    else if (k < 6) v[14:8] = 7'(int'(other[14:8]) + int'($urandom_range(6)) - 3);
    else if (k == 6) v = other ^ 16'h8000 ^ ($urandom_range(1) ? 16'h0001 : 16'h0000);
    return v;
  endfunction

  task automatic send(logic [15:0] a, logic [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic run_random(int count, int idle, int stall);
    logic [15:0] a;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) begin
      a = 16'($urandom());
      send(a, pick_operand(a));
    end
  endtask

  initial begin
    int i;
    // extremes, NaN, infinities, zeros, cancellation, subnormals, overflow
    directed_a = '{16'h0000, 16'h8000, 16'h7f01, 16'h3f00, 16'h7f00, 16'h7f00, 16'h7f00,
                   16'h0000, 16'h3f80, 16'h3f00, 16'h0001, 16'h00ff, 16'h7eff, 16'hfeff,
                   16'h3f00, 16'h3f01, 16'hffff, 16'h4000, 16'h0100, 16'h3fff, 16'h7fff};
    directed_b = '{16'h0000, 16'h0000, 16'h3f00, 16'hff80, 16'hff00, 16'h7f00, 16'h3f00,
                   16'h4123, 16'hbf80, 16'h3100, 16'h0001, 16'h0001, 16'h7eff, 16'hfe80,
                   16'hb4ff, 16'hbf00, 16'h0000, 16'hbfff, 16'h80ff, 16'h3080, 16'h7fff};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < directed_a.size(); i++) send(directed_a[i], directed_b[i]);
    run_random(500, 0, 0);
    run_random(400, 81, 0);
    run_random(400, 0, 81);
    run_random(400, 20, 20);
    // long receiver hold-off while items keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off <= 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      run_random(40, 0, 0);
    join
    run_random(300, 0, 0);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
